### rtl/core/twc_pkg.sv
// ----------------------------------------------------------------------------
// twc_pkg: shared types and constants for the textured wall column core
// controller state, command and status bundles, field widths, register codes
// ----------------------------------------------------------------------------
`default_nettype none

package twc_pkg;

  // default geometry
  localparam int SCREEN_HEIGHT_DEF = 64;
  localparam int TEXTURE_SIZE_DEF  = 64;

  // fixed field widths
  localparam int COL_W   = 12;
  localparam int WH_W    = 16;
  localparam int DIST_W  = 16;
  localparam int TX_W    = 6;
  localparam int TIDX_W  = 3;
  localparam int ROW_O_W = 6;
  localparam int SHEET_W = 9;
  localparam int TROW_W  = 6;
  localparam int FRAC_W  = 16;
  localparam int HGT_W   = WH_W + 1;  // height after the +2 bias
  localparam int HALF_W  = 16;        // clipped half, below 2^15

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DEPTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEPTH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_PRIME,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;      // capture a column
    logic div_step;  // one quotient bit
    logic mul_step;  // one bit of half * step mod wrap
    logic v_adv;     // advance v by step
    logic row_adv;   // beat taken, move to the next row
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic mul_last;
    logic clip;
    logic row_last;
  } status_t;

endpackage

`default_nettype wire

### rtl/core/twc_ctrl.sv
// ----------------------------------------------------------------------------
// twc_ctrl: sequencer for the textured wall column core
// steps divide, clip offset, prime and row emission over the datapath
// ----------------------------------------------------------------------------
`default_nettype none

module twc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  input  wire twc_pkg::status_t sts,
  output twc_pkg::cmd_t        cmd
);

  twc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= twc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      twc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = twc_pkg::ST_DIV;
        end
      end
      twc_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = sts.clip ? twc_pkg::ST_MUL : twc_pkg::ST_PRIME;
        end
      end
      twc_pkg::ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (sts.mul_last) begin
          state_nxt = twc_pkg::ST_PRIME;
        end
      end
      twc_pkg::ST_PRIME: begin
        cmd.v_adv = 1'b1;
        state_nxt = twc_pkg::ST_EMIT;
      end
      twc_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.row_adv = 1'b1;
          if (sts.row_last) begin
            state_nxt = twc_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = twc_pkg::ST_IDLE;
      end
    endcase
  end

  // a column is never taken while a beat is offered
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken during emission");

  a_load_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == twc_pkg::ST_DIV))
    else $error("divide did not start after load");

  a_noclip_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == twc_pkg::ST_DIV && sts.div_last && !sts.clip)
      |=> (state_r == twc_pkg::ST_PRIME))
    else $error("unclipped column entered clip offset");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && sts.row_last) |=> in_ready)
    else $error("not idle after last beat");

endmodule

`default_nettype wire

### rtl/core/twc_dp.sv
// ----------------------------------------------------------------------------
// twc_dp: datapath of the textured wall column core
// restoring divider, modular shift-add for the clip offset, row generator
// ----------------------------------------------------------------------------
`default_nettype none

module twc_dp #(
  parameter int SCREEN_HEIGHT = twc_pkg::SCREEN_HEIGHT_DEF,
  parameter int TEXTURE_SIZE  = twc_pkg::TEXTURE_SIZE_DEF
) (
  input  wire logic                        clk,
  input  wire twc_pkg::cmd_t               cmd,
  output twc_pkg::status_t                 sts,
  input  wire logic [twc_pkg::COL_W-1:0]   in_column,
  input  wire logic [twc_pkg::WH_W-1:0]    in_wall_height,
  input  wire logic [twc_pkg::DIST_W-1:0]  in_distance,
  input  wire logic [twc_pkg::TX_W-1:0]    in_texture_x,
  input  wire logic [twc_pkg::TIDX_W-1:0]  in_texture_index,
  input  wire logic                        in_is_empty,
  input  wire logic [twc_pkg::DIST_W-1:0]  min_depth,
  input  wire logic [twc_pkg::DIST_W-1:0]  max_depth,
  output logic [twc_pkg::COL_W-1:0]        out_column,
  output logic [twc_pkg::ROW_O_W-1:0]      out_screen_row,
  output logic [twc_pkg::SHEET_W-1:0]      out_sheet_column,
  output logic [twc_pkg::TROW_W-1:0]       out_texture_row,
  output logic                             out_blank,
  output logic [twc_pkg::DIST_W-1:0]       out_depth,
  output logic                             out_last
);

  localparam int WRAP    = TEXTURE_SIZE * (2 ** twc_pkg::FRAC_W);
  localparam int WRAP_W  = $clog2(WRAP + 1);
  localparam int DCNT_W  = $clog2(WRAP_W);
  localparam int MCNT_W  = $clog2(twc_pkg::HALF_W);
  localparam int ROW_W   = $clog2(SCREEN_HEIGHT + 1);
  localparam int HGT_W   = twc_pkg::HGT_W;
  localparam logic [WRAP_W-1:0] WrapVal = WRAP_W'(WRAP);
  localparam logic [HGT_W-1:0]  ScrH    = HGT_W'(SCREEN_HEIGHT);
  localparam logic [ROW_W-1:0]  ScrHalf = ROW_W'(SCREEN_HEIGHT / 2);

  logic [HGT_W-1:0]                height_r;
  logic [HGT_W-1:0]                rem_r;
  logic [WRAP_W-1:0]               q_r;
  logic [WRAP_W-1:0]               v_r;
  logic [DCNT_W-1:0]               div_cnt_r;
  logic [MCNT_W-1:0]               mul_cnt_r;
  logic [twc_pkg::HALF_W-1:0]      half_r;
  logic                            clip_r;
  logic [ROW_W-1:0]                rows_left_r;
  logic [twc_pkg::ROW_O_W-1:0]     row_pos_r;
  logic [twc_pkg::COL_W-1:0]       col_r;
  logic [twc_pkg::SHEET_W-1:0]     sheet_r;
  logic                            empty_r;
  logic [twc_pkg::DIST_W-1:0]      depth_r;

  // load-time values
  logic [HGT_W-1:0]           height_in;
  logic                       clip_in;
  logic [HGT_W-1:0]           over_in;
  logic [ROW_W-1:0]           rows_in;
  logic [ROW_W-1:0]           start_in;
  logic [twc_pkg::DIST_W-1:0] dlow;

  // divider step
  logic [HGT_W:0] trial;
  logic           ge;

  // modular arithmetic
  logic [WRAP_W:0]   dbl;
  logic [WRAP_W-1:0] dbl_red;
  logic [WRAP_W-1:0] addend;
  logic [WRAP_W:0]   msum;
  logic [WRAP_W-1:0] msum_red;
  logic [WRAP_W:0]   asum;
  logic [WRAP_W-1:0] asum_red;
  logic [WRAP_W+5:0] v_ext;

  always_comb begin
    height_in = HGT_W'(in_wall_height) + HGT_W'(2);
    clip_in   = height_in > ScrH;
    over_in   = height_in - ScrH;
    rows_in   = clip_in ? ROW_W'(SCREEN_HEIGHT) : ROW_W'(height_in);
    start_in  = ScrHalf - (rows_in >> 1);
    dlow      = (in_distance < min_depth) ? min_depth : in_distance;

    trial = {rem_r, WrapVal[div_cnt_r]};
    ge    = trial >= {1'b0, height_r};

    dbl      = {v_r, 1'b0};
    dbl_red  = (dbl >= {1'b0, WrapVal}) ? WRAP_W'(dbl - {1'b0, WrapVal}) : WRAP_W'(dbl);
    addend   = half_r[mul_cnt_r] ? q_r : '0;
    msum     = {1'b0, dbl_red} + {1'b0, addend};
    msum_red = (msum >= {1'b0, WrapVal}) ? WRAP_W'(msum - {1'b0, WrapVal}) : WRAP_W'(msum);
    asum     = {1'b0, v_r} + {1'b0, q_r};
    asum_red = (asum >= {1'b0, WrapVal}) ? WRAP_W'(asum - {1'b0, WrapVal}) : WRAP_W'(asum);
    v_ext    = (WRAP_W+6)'(v_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      height_r    <= height_in;
      rem_r       <= '0;
      q_r         <= '0;
      v_r         <= '0;
      div_cnt_r   <= DCNT_W'(WRAP_W - 1);
      mul_cnt_r   <= MCNT_W'(twc_pkg::HALF_W - 1);
      half_r      <= clip_in ? twc_pkg::HALF_W'(over_in >> 1) : '0;
      clip_r      <= clip_in;
      rows_left_r <= rows_in;
      row_pos_r   <= twc_pkg::ROW_O_W'(start_in);
      col_r       <= in_column;
      sheet_r     <= in_is_empty ? '0 : {in_texture_index, in_texture_x};
      empty_r     <= in_is_empty;
      depth_r     <= (dlow > max_depth) ? max_depth : dlow;
    end
    if (cmd.div_step) begin
      rem_r     <= ge ? HGT_W'(trial - {1'b0, height_r}) : HGT_W'(trial);
      q_r       <= {q_r[WRAP_W-2:0], ge};
      div_cnt_r <= div_cnt_r - DCNT_W'(1);
    end
    if (cmd.mul_step) begin
      v_r       <= msum_red;
      mul_cnt_r <= mul_cnt_r - MCNT_W'(1);
    end
    if (cmd.v_adv || cmd.row_adv) begin
      v_r <= asum_red;
    end
    if (cmd.row_adv) begin
      rows_left_r <= rows_left_r - ROW_W'(1);
      row_pos_r   <= row_pos_r + twc_pkg::ROW_O_W'(1);
    end
  end

  always_comb begin
    sts.div_last = div_cnt_r == '0;
    sts.mul_last = mul_cnt_r == '0;
    sts.clip     = clip_r;
    sts.row_last = rows_left_r == ROW_W'(1);
  end

  assign out_column       = col_r;
  assign out_screen_row   = row_pos_r;
  assign out_sheet_column = sheet_r;
  assign out_texture_row  = empty_r ? '0 : v_ext[twc_pkg::FRAC_W +: twc_pkg::TROW_W];
  assign out_blank        = empty_r;
  assign out_depth        = depth_r;
  assign out_last         = rows_left_r == ROW_W'(1);

endmodule

`default_nettype wire

### rtl/core/textured_wall_column_span_core.sv
// ----------------------------------------------------------------------------
// textured_wall_column_span_core: textured wall column span generator
// turns one raycast column into one pixel beat per drawn screen row
// ----------------------------------------------------------------------------
// One column at a time. After a column is taken, a restoring divider forms the
// texture step TEXTURE_SIZE / (wall_height + 2), Q7.16 at the default texture
// size, at one quotient bit per cycle. A wall taller than the screen then goes
// through a shift-add unit that forms the starting v as half * step modulo the
// texture wrap. A prime step advances v by the texture step, and then one pixel
// beat leaves per cycle while out_ready is high, top row first, with last set
// on the final row. The user must write min_depth and max_depth through the cfg
// port only while no column is in flight; the core does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module textured_wall_column_span_core #(
  parameter int SCREEN_HEIGHT = twc_pkg::SCREEN_HEIGHT_DEF,
  parameter int TEXTURE_SIZE  = twc_pkg::TEXTURE_SIZE_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration writes
  input  wire logic                              cfg_we,
  input  wire logic [twc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [twc_pkg::DIST_W-1:0]        cfg_wdata,
  // column input
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [twc_pkg::COL_W-1:0]         in_column,
  input  wire logic [twc_pkg::WH_W-1:0]          in_wall_height,
  input  wire logic [twc_pkg::DIST_W-1:0]        in_distance,
  input  wire logic [twc_pkg::TX_W-1:0]          in_texture_x,
  input  wire logic [twc_pkg::TIDX_W-1:0]        in_texture_index,
  input  wire logic                              in_is_empty,
  // pixel output
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [twc_pkg::COL_W-1:0]              out_column,
  output logic [twc_pkg::ROW_O_W-1:0]            out_screen_row,
  output logic [twc_pkg::SHEET_W-1:0]            out_sheet_column,
  output logic [twc_pkg::TROW_W-1:0]             out_texture_row,
  output logic                                   out_blank,
  output logic [twc_pkg::DIST_W-1:0]             out_depth,
  output logic                                   out_last
);

  // depth clamp registers, low bound applied first so max wins when crossed
  logic [twc_pkg::DIST_W-1:0] min_depth_r, min_depth_nxt;
  logic [twc_pkg::DIST_W-1:0] max_depth_r, max_depth_nxt;

  always_comb begin
    min_depth_nxt = min_depth_r;
    max_depth_nxt = max_depth_r;
    if (cfg_we) begin
      unique case (cfg_index)
        twc_pkg::CFG_MIN_DEPTH: min_depth_nxt = cfg_wdata;
        twc_pkg::CFG_MAX_DEPTH: max_depth_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_depth_r <= twc_pkg::DIST_W'(1);
      max_depth_r <= '1;
    end else begin
      min_depth_r <= min_depth_nxt;
      max_depth_r <= max_depth_nxt;
    end
  end

  // command and status between sequencer and datapath
  twc_pkg::cmd_t    cmd;
  twc_pkg::status_t sts;

  twc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  twc_dp #(
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .TEXTURE_SIZE  (TEXTURE_SIZE)
  ) u_dp (
    .clk              (clk),
    .cmd              (cmd),
    .sts              (sts),
    .in_column        (in_column),
    .in_wall_height   (in_wall_height),
    .in_distance      (in_distance),
    .in_texture_x     (in_texture_x),
    .in_texture_index (in_texture_index),
    .in_is_empty      (in_is_empty),
    .min_depth        (min_depth_r),
    .max_depth        (max_depth_r),
    .out_column       (out_column),
    .out_screen_row   (out_screen_row),
    .out_sheet_column (out_sheet_column),
    .out_texture_row  (out_texture_row),
    .out_blank        (out_blank),
    .out_depth        (out_depth),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for textured_wall_column_span_core
// offers raycast columns through the in_ channel, writes the depth clamps
// while the core is idle, and checks every pixel beat against an in-bench
// span predictor under bursty input and a stalling receiver
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import twc_pkg::*;

  localparam int ROWS        = SCREEN_HEIGHT_DEF;
  localparam int TEX         = TEXTURE_SIZE_DEF;
  localparam int HEIGHT_BIAS = 2;
  localparam longint unsigned WRAP = longint'(TEX) << FRAC_W;

  localparam int PHASES      = 5;
  localparam int PHASE_ITEMS = 58;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_LIMIT = 50_000;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SHOW_LIMIT  = 10;

  typedef struct packed {
    logic [COL_W-1:0]  column;
    logic [WH_W-1:0]   wall_height;
    logic [DIST_W-1:0] distance;
    logic [TX_W-1:0]   texture_x;
    logic [TIDX_W-1:0] texture_index;
    logic              is_empty;
  } column_t;

  typedef struct packed {
    logic [COL_W-1:0]   column;
    logic [ROW_O_W-1:0] screen_row;
    logic [SHEET_W-1:0] sheet_column;
    logic [TROW_W-1:0]  texture_row;
    logic               blank;
    logic [DIST_W-1:0]  depth;
    logic               last;
  } pixel_t;

  typedef enum logic {STEP_COLUMN, STEP_WRITE} step_kind_t;

  // receiver stall styles
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PATTERN, RX_SPARSE} rx_mode_t;

  // one row of the directed table; a known row carries hand-typed span facts
  typedef struct packed {
    step_kind_t           kind;
    column_t              col;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [DIST_W-1:0]    reg_value;
    logic                 known;
    logic [6:0]           rows;
    logic [ROW_O_W-1:0]   top_row;
    logic [SHEET_W-1:0]   sheet_column;
    logic                 blank;
    logic [DIST_W-1:0]    depth;
  } step_t;

  // dut ports
  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIST_W-1:0]    cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic [COL_W-1:0]     in_column;
  logic [WH_W-1:0]      in_wall_height;
  logic [DIST_W-1:0]    in_distance;
  logic [TX_W-1:0]      in_texture_x;
  logic [TIDX_W-1:0]    in_texture_index;
  logic                 in_is_empty;
  logic                 out_valid;
  logic                 out_ready;
  logic [COL_W-1:0]     out_column;
  logic [ROW_O_W-1:0]   out_screen_row;
  logic [SHEET_W-1:0]   out_sheet_column;
  logic [TROW_W-1:0]    out_texture_row;
  logic                 out_blank;
  logic [DIST_W-1:0]    out_depth;
  logic                 out_last;

  // bench state
  pixel_t            pending_pixels[$];  // beats owed by the core, oldest first
  step_t             plan[$];            // directed table
  logic [DIST_W-1:0] depth_floor;        // mirror of min_depth
  logic [DIST_W-1:0] depth_ceiling;      // mirror of max_depth
  int                mismatch_count = 0;
  int                burst_left     = 0;
  int                hold_asks      = 0; // bumped to ask the receiver for a long stall
  int                cycle_count    = 0;

  textured_wall_column_span_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_column        (in_column),
    .in_wall_height   (in_wall_height),
    .in_distance      (in_distance),
    .in_texture_x     (in_texture_x),
    .in_texture_index (in_texture_index),
    .in_is_empty      (in_is_empty),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_column       (out_column),
    .out_screen_row   (out_screen_row),
    .out_sheet_column (out_sheet_column),
    .out_texture_row  (out_texture_row),
    .out_blank        (out_blank),
    .out_depth        (out_depth),
    .out_last         (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // hard stop if the run hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[textured_wall_column_span_core] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // span predictor: queues every pixel beat one column owes, top row first
  // ---------------------------------------------------------------------------
  task automatic expect_column(input step_t s);
    logic [HGT_W-1:0]   height;
    longint unsigned    tex_step, v, half;
    int unsigned        rows, top;
    logic [DIST_W-1:0]  depth;
    logic [SHEET_W-1:0] sheet;
    logic               blank;
    pixel_t             px;
    height   = HGT_W'(s.col.wall_height + HEIGHT_BIAS);
    tex_step = WRAP / height;
    v        = 0;
    if (height > ROWS) begin
      // taller than the screen: clip, start v halfway into the hidden part
      half = 64'((height - ROWS) / 2);
      v    = (half * tex_step) % WRAP;
      rows = ROWS;
    end else begin
      rows = 32'(height);
    end
    top   = ROWS / 2 - rows / 2;
    depth = s.col.distance;
    // floor first, ceiling second, so crossed clamps end on max_depth
    if (depth < depth_floor) depth = depth_floor;
    if (depth > depth_ceiling) depth = depth_ceiling;
    // sheet stride equals the texture width, so the sum is a concatenation
    sheet = s.col.is_empty ? '0 : {s.col.texture_index, s.col.texture_x};
    blank = s.col.is_empty;
    if (s.known) begin
      rows  = 32'(s.rows);
      top   = 32'(s.top_row);
      sheet = s.sheet_column;
      blank = s.blank;
      depth = s.depth;
    end
    for (int unsigned i = 0; i < rows; i++) begin
      v = (v + tex_step) % WRAP;   // advance first, then read the row
      px.column       = s.col.column;
      px.screen_row   = ROW_O_W'(top + i);
      px.sheet_column = sheet;
      px.texture_row  = s.col.is_empty ? '0 : TROW_W'((v >> FRAC_W) % TEX);
      px.blank        = blank;
      px.depth        = depth;
      px.last         = (i + 1 == rows);
      pending_pixels.push_back(px);
    end
  endtask

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------
  // holds the column until the core takes it, then predicts its beats
  task automatic offer_column(input step_t s);
    in_valid         <= 1'b1;
    in_column        <= s.col.column;
    in_wall_height   <= s.col.wall_height;
    in_distance      <= s.col.distance;
    in_texture_x     <= s.col.texture_x;
    in_texture_index <= s.col.texture_index;
    in_is_empty      <= s.col.is_empty;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expect_column(s);
  endtask

  // bursts of back-to-back columns, random gaps between bursts
  task automatic pace_sender();
    int gap;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // stop offering and wait for every owed beat; the core is then idle
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [DIST_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MIN_DEPTH) depth_floor = value;
    else depth_ceiling = value;
  endtask

  // ---------------------------------------------------------------------------
  // stimulus builders
  // ---------------------------------------------------------------------------
  function automatic column_t make_column(input int unsigned column, wall_height, distance,
                                          texture_x, texture_index, input bit is_empty);
    column_t c;
    c.column        = COL_W'(column);
    c.wall_height   = WH_W'(wall_height);
    c.distance      = DIST_W'(distance);
    c.texture_x     = TX_W'(texture_x);
    c.texture_index = TIDX_W'(texture_index);
    c.is_empty      = is_empty;
    return c;
  endfunction

  task automatic add_plain(input column_t c);
    step_t s;
    s      = '0;
    s.kind = STEP_COLUMN;
    s.col  = c;
    plan.push_back(s);
  endtask

  task automatic add_known(input column_t c, input int unsigned rows, top, sheet,
                           input bit blank, input int unsigned depth);
    step_t s;
    s              = '0;
    s.kind         = STEP_COLUMN;
    s.col          = c;
    s.known        = 1'b1;
    s.rows         = 7'(rows);
    s.top_row      = ROW_O_W'(top);
    s.sheet_column = SHEET_W'(sheet);
    s.blank        = blank;
    s.depth        = DIST_W'(depth);
    plan.push_back(s);
  endtask

  task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    step_t s;
    s           = '0;
    s.kind      = STEP_WRITE;
    s.reg_index = idx;
    s.reg_value = DIST_W'(value);
    plan.push_back(s);
  endtask

  // mostly on-screen and just-clipped walls, some tall ones, distances near the clamps
  function automatic column_t random_column();
    column_t c;
    int      pick;
    c.column = COL_W'($urandom_range(0, 4095));
    pick = $urandom_range(0, 99);
    if (pick < 55)      c.wall_height = WH_W'($urandom_range(0, 62));
    else if (pick < 75) c.wall_height = WH_W'($urandom_range(63, 130));
    else if (pick < 92) c.wall_height = WH_W'($urandom_range(131, 4000));
    else                c.wall_height = WH_W'($urandom_range(4001, 65535));
    pick = $urandom_range(0, 9);
    case (pick)
      0: c.distance = depth_floor;
      1: c.distance = depth_ceiling;
      2: c.distance = (depth_floor > 1) ? depth_floor - 1'b1 : depth_floor;
      3: c.distance = (depth_ceiling != '1) ? depth_ceiling + 1'b1 : depth_ceiling;
      default: c.distance = DIST_W'($urandom_range(1, 65535));
    endcase
    c.texture_x     = TX_W'($urandom_range(0, 63));
    c.texture_index = TIDX_W'($urandom_range(0, 7));
    c.is_empty      = ($urandom_range(0, 7) == 0);
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // receiver side: stall styles change every segment, long hold on request
  // ---------------------------------------------------------------------------
  initial begin : receiver
    rx_mode_t   mode;
    int         seg_left;
    int         tick;
    int         hold_left;
    int         hold_taken;
    logic [7:0] pattern;
    logic       ready_next;
    out_ready  = 1'b0;
    mode       = RX_OPEN;
    seg_left   = 0;
    tick       = 0;
    hold_left  = 0;
    hold_taken = 0;
    pattern    = 8'hff;
    forever begin
      @(posedge clk);
      if (seg_left == 0) begin
        mode     = rx_mode_t'($urandom_range(0, 3));
        seg_left = $urandom_range(20, 200);
        pattern  = 8'($urandom);
        if (pattern == '0) pattern = 8'h01;
      end
      seg_left--;
      if (hold_asks != hold_taken) begin
        hold_taken = hold_asks;
        hold_left  = HOLD_CYCLES;
      end
      case (mode)
        RX_OPEN:    ready_next = 1'b1;
        RX_COIN:    ready_next = 1'($urandom_range(0, 1));
        RX_PATTERN: ready_next = pattern[tick % 8];
        default:    ready_next = ($urandom_range(0, 7) != 0);
      endcase
      tick++;
      // long hold: the core fills with one column and must drop in_ready
      if (hold_left != 0) begin
        hold_left--;
        ready_next = 1'b0;
      end
      out_ready <= ready_next;
    end
  end

  // ---------------------------------------------------------------------------
  // beat checker
  // ---------------------------------------------------------------------------
  task automatic note_fault(input string what, input pixel_t want, input pixel_t got);
    mismatch_count++;
    if (mismatch_count <= SHOW_LIMIT)
      $display("%0t %s: exp col=%0d row=%0d sheet=%0d trow=%0d blank=%0b depth=%h last=%0b",
               $time, what, want.column, want.screen_row, want.sheet_column,
               want.texture_row, want.blank, want.depth, want.last,
               "\n    got col=%0d row=%0d sheet=%0d trow=%0d blank=%0b depth=%h last=%0b",
               got.column, got.screen_row, got.sheet_column, got.texture_row,
               got.blank, got.depth, got.last);
  endtask

  always @(posedge clk) begin : pixel_check
    pixel_t got;
    pixel_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_column, out_screen_row, out_sheet_column, out_texture_row,
             out_blank, out_depth, out_last};
      if (pending_pixels.size() == 0) begin
        note_fault("beat with nothing owed", '0, got);
      end else begin
        want = pending_pixels.pop_front();
        if (got !== want) note_fault("beat mismatch", want, got);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_flow
    step_t             s;
    int                wait_left;
    logic [DIST_W-1:0] lo;
    logic [DIST_W-1:0] hi;

    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_MIN_DEPTH;
    cfg_wdata        = '0;
    in_valid         = 1'b0;
    in_column        = '0;
    in_wall_height   = '0;
    in_distance      = '0;
    in_texture_x     = '0;
    in_texture_index = '0;
    in_is_empty      = 1'b0;
    depth_floor      = 16'd1;
    depth_ceiling    = 16'hffff;

    // reset clamps: floor 1, ceiling 65535
    // zero height still gives two rows around the middle
    add_known(make_column(0, 0, 16'h0100, 0, 0, 0), 2, 31, 0, 0, 16'h0100);
    // exactly screen height, widest sheet column, farthest distance
    add_known(make_column(4095, 62, 16'hffff, 63, 7, 0), 64, 0, 511, 0, 16'hffff);
    // one row short of the screen, nearest distance
    add_known(make_column(1, 61, 1, 5, 1, 0), 63, 1, 69, 0, 1);
    // tallest wall, clipped deep into the texture
    add_known(make_column(4095, 65535, 16'h1234, 63, 7, 0), 64, 0, 511, 0, 16'h1234);
    // clipped with a zero hidden half
    add_known(make_column(2, 63, 16'h8000, 0, 7, 0), 64, 0, 448, 0, 16'h8000);
    // empty columns draw blank with zeroed texture coordinates
    add_known(make_column(3, 1, 16'h0200, 63, 7, 1), 3, 31, 0, 1, 16'h0200);
    add_known(make_column(4, 65535, 16'hffff, 63, 7, 1), 64, 0, 0, 1, 16'hffff);
    add_plain(make_column(5, 64, 16'h0300, 10, 2, 0));
    add_plain(make_column(6, 2, 16'h0400, 33, 3, 0));
    add_plain(make_column(7, 1000, 16'h0500, 17, 4, 0));
    add_plain(make_column(8, 16'h5555, 16'haaaa, 42, 5, 0));
    add_plain(make_column(9, 30, 16'h00ff, 21, 6, 0));
    // narrow clamp window: below, above, inside
    add_write(CFG_MIN_DEPTH, 16'h2000);
    add_write(CFG_MAX_DEPTH, 16'h3000);
    add_known(make_column(10, 10, 16'h1000, 1, 1, 0), 12, 26, 65, 0, 16'h2000);
    add_known(make_column(11, 10, 16'h4000, 2, 1, 0), 12, 26, 66, 0, 16'h3000);
    add_known(make_column(12, 10, 16'h2800, 3, 1, 0), 12, 26, 67, 0, 16'h2800);
    // crossed clamps: the ceiling always wins
    add_write(CFG_MIN_DEPTH, 16'h8000);
    add_write(CFG_MAX_DEPTH, 16'h0100);
    add_known(make_column(13, 4, 16'h9000, 0, 0, 0), 6, 29, 0, 0, 16'h0100);
    add_known(make_column(14, 4, 1, 0, 0, 0), 6, 29, 0, 0, 16'h0100);
    // both clamps at the top, then both at the bottom
    add_write(CFG_MIN_DEPTH, 16'hffff);
    add_write(CFG_MAX_DEPTH, 16'hffff);
    add_known(make_column(15, 0, 1, 63, 0, 0), 2, 31, 63, 0, 16'hffff);
    add_write(CFG_MIN_DEPTH, 1);
    add_write(CFG_MAX_DEPTH, 1);
    add_known(make_column(16, 0, 16'hffff, 0, 1, 0), 2, 31, 64, 0, 1);
    add_write(CFG_MAX_DEPTH, 16'hffff);
    add_plain(make_column(17, 63, 16'h7fff, 31, 2, 1));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (plan[i]) begin
      if (plan[i].kind == STEP_WRITE) begin
        settle_idle();
        write_register(plan[i].reg_index, plan[i].reg_value);
      end else begin
        offer_column(plan[i]);
        pace_sender();
      end
    end

    // random phases, each under its own clamp setting
    for (int p = 0; p < PHASES; p++) begin
      settle_idle();
      case (p)
        0: begin
          lo = 16'd1;
          hi = 16'hffff;
        end
        1: begin
          lo = DIST_W'($urandom_range(1, 16'h7fff));
          hi = DIST_W'($urandom_range(lo, 16'hffff));
        end
        2: begin
          lo = DIST_W'($urandom_range(16'h8000, 16'hffff));
          hi = DIST_W'($urandom_range(1, 16'h7fff));
        end
        3: begin
          lo = DIST_W'($urandom_range(1, 16'hffff));
          hi = DIST_W'($urandom_range(1, 16'hffff));
        end
        default: begin
          lo = DIST_W'($urandom_range(1, 16'hffff));
          hi = lo;
        end
      endcase
      write_register(CFG_MIN_DEPTH, lo);
      write_register(CFG_MAX_DEPTH, hi);
      // long receiver hold while the sender keeps offering with no gaps
      if (p == 0 || p == 3) begin
        hold_asks++;
        burst_left = 24;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        s      = '0;
        s.kind = STEP_COLUMN;
        s.col  = random_column();
        offer_column(s);
        pace_sender();
      end
    end

    // drain, then a short quiet window to catch stray beats
    in_valid <= 1'b0;
    wait_left = DRAIN_LIMIT;
    while (pending_pixels.size() != 0 && wait_left != 0) begin
      @(posedge clk);
      wait_left--;
    end
    repeat (40) @(posedge clk);
    if (pending_pixels.size() != 0)
      $display("%0t %0d expected beats never arrived", $time, pending_pixels.size());

    if (mismatch_count == 0 && pending_pixels.size() == 0) begin
      $display("[textured_wall_column_span_core] OK");
    end else begin
      $display("[textured_wall_column_span_core] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
